/* src/hhslp_pkg.sv */
// Package for the HTTP header status/length parser.
// Holds command and outcome codes, the fixed prefix tables and the reset constants.
// No dependencies.
`timescale 1ns / 1ps

package hhslp_pkg;

	localparam int LINE_CAP_DEF = 256;

	localparam logic [15:0] MAX_HDR_RESET = 16'd2000;
	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

	localparam int STATUS_PREFIX_LEN = 5;
	localparam int STATUS_COL        = 9;
	localparam int LENGTH_PREFIX_LEN = 16;
	localparam int LENGTH_COL        = 16;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_MAX_HDR = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_CLOSE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OUT_RUNNING      = 3'd0,
		OUT_HEADER_END   = 3'd1,
		OUT_TOO_LARGE    = 3'd2,
		OUT_TIMEOUT      = 3'd3,
		OUT_CLOSED_EMPTY = 3'd4,
		OUT_CLOSED_BYTES = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		NUM_SKIP   = 2'd0,
		NUM_DIGITS = 2'd1,
		NUM_DONE   = 2'd2
	} num_phase_t;

	// "HTTP/"
	function automatic logic [7:0] status_prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = "H";
			3'd1:    ch = "T";
			3'd2:    ch = "T";
			3'd3:    ch = "P";
			3'd4:    ch = "/";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "Content-Length: "
	function automatic logic [7:0] length_prefix_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = "C";
			4'd1:    ch = "o";
			4'd2:    ch = "n";
			4'd3:    ch = "t";
			4'd4:    ch = "e";
			4'd5:    ch = "n";
			4'd6:    ch = "t";
			4'd7:    ch = "-";
			4'd8:    ch = "L";
			4'd9:    ch = "e";
			4'd10:   ch = "n";
			4'd11:   ch = "g";
			4'd12:   ch = "t";
			4'd13:   ch = "h";
			4'd14:   ch = ":";
			4'd15:   ch = " ";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* src/hhslp_in_if.sv */
// Input channel of the header parser: command and received byte.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface hhslp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;

	modport source (output valid, cmd, data_byte, input ready);
	modport sink (input valid, cmd, data_byte, output ready);
endinterface

/* src/hhslp_out_if.sv */
// Result channel of the header parser: outcome and parsed values.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface hhslp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  outcome;
	logic        finished;
	logic [15:0] status_code;
	logic [15:0] content_length;

	modport source (output valid, outcome, finished, status_code, content_length,
		input ready);
	modport sink (input valid, outcome, finished, status_code, content_length,
		output ready);
endinterface

/* src/http_header_status_length_parser_unit.sv */
// Top level of the HTTP response header parser (status code, content length).
// Each accepted item's result is loaded into a registered output stage.
// Throughput: one item per cycle while results are drained; the per-byte scan state updates in a single pass.
// An item is taken whenever the output register is empty or being drained.
// arst_n clears the scan state as after a start and loads the register defaults.
// Depends on hhslp_pkg, hhslp_in_if and hhslp_out_if.
`timescale 1ns / 1ps

module http_header_status_length_parser_unit
	import hhslp_pkg::*;
#(
	parameter int LINE_CAP = LINE_CAP_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	hhslp_in_if.sink     req,
	hhslp_out_if.source  rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int CW = $clog2(LINE_CAP);

	// configuration registers
	logic [15:0] max_hdr_q;
	logic [31:0] timeout_q;

	// scan state
	outcome_t    phase_q, phase_d;
	logic [15:0] byte_count_q, byte_count_d;
	logic [CW-1:0] column_q, column_d;
	logic        status_ok_q, status_ok_d;
	logic        length_ok_q, length_ok_d;
	logic [15:0] accum_q, accum_d;
	num_phase_t  num_phase_q, num_phase_d;
	logic        negative_q, negative_d;
	logic [1:0]  nl_run_q, nl_run_d;
	logic [31:0] elapsed_q, elapsed_d;
	logic [15:0] status_val_q, status_val_d;
	logic [15:0] length_val_q, length_val_d;

	logic        out_valid_q;
	logic        accept;
	logic        conv_en;
	logic        is_digit;
	logic [7:0]  ch;
	logic [15:0] line_value;
	logic [31:0] elapsed_inc;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_q : {16'd0, max_hdr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q <= MAX_HDR_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MAX_HDR) max_hdr_q <= pwdata[15:0];
			else timeout_q <= pwdata;
		end
	end

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign ch        = req.data_byte;
	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign line_value = negative_q ? (16'd0 - accum_q) : accum_q;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;

	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		column_d     = column_q;
		status_ok_d  = status_ok_q;
		length_ok_d  = length_ok_q;
		accum_d      = accum_q;
		num_phase_d  = num_phase_q;
		negative_d   = negative_q;
		nl_run_d     = nl_run_q;
		elapsed_d    = elapsed_q;
		status_val_d = status_val_q;
		length_val_d = length_val_q;
		conv_en      = 1'b0;

		if (cmd_t'(req.cmd) == CMD_START) begin
			phase_d      = OUT_RUNNING;
			byte_count_d = '0;
			column_d     = '0;
			status_ok_d  = 1'b1;
			length_ok_d  = 1'b1;
			accum_d      = '0;
			num_phase_d  = NUM_SKIP;
			negative_d   = 1'b0;
			nl_run_d     = '0;
			elapsed_d    = '0;
			status_val_d = '0;
			length_val_d = '0;
		end else if (phase_q == OUT_RUNNING) begin
			case (cmd_t'(req.cmd))
				CMD_BYTE: begin
					if (elapsed_q >= timeout_q) begin
						phase_d = OUT_TIMEOUT;
					end else if (byte_count_q >= max_hdr_q) begin
						phase_d = OUT_TOO_LARGE;
					end else begin
						byte_count_d = byte_count_q + 16'd1;
						if (ch != CH_CR && ch != CH_LF) begin
							nl_run_d = '0;
							if (column_q < CW'(LINE_CAP - 1)) begin
								if (column_q < CW'(STATUS_PREFIX_LEN) &&
								    ch != status_prefix_char(column_q[2:0]))
									status_ok_d = 1'b0;
								if (column_q < CW'(LENGTH_PREFIX_LEN) &&
								    ch != length_prefix_char(column_q[3:0]))
									length_ok_d = 1'b0;
								// prefix flags as updated by this character
								if (status_ok_d && column_q >= CW'(STATUS_COL))
									conv_en = 1'b1;
								else if (length_ok_d && column_q >= CW'(LENGTH_COL))
									conv_en = 1'b1;
								column_d = column_q + CW'(1);
							end
						end
						if (conv_en) begin
							case (num_phase_q)
								NUM_SKIP: begin
									if (ch == CH_SP || ch == CH_TAB ||
									    ch == CH_VT || ch == CH_FF) begin
										num_phase_d = NUM_SKIP;
									end else if (ch == CH_PLUS || ch == CH_MINUS) begin
										negative_d  = (ch == CH_MINUS);
										num_phase_d = NUM_DIGITS;
									end else if (is_digit) begin
										accum_d     = {12'd0, ch[3:0]};
										num_phase_d = NUM_DIGITS;
									end else begin
										num_phase_d = NUM_DONE;
									end
								end
								NUM_DIGITS: begin
									if (is_digit)
										accum_d = (accum_q << 3) + (accum_q << 1) +
											{12'd0, ch[3:0]};
									else
										num_phase_d = NUM_DONE;
								end
								default: num_phase_d = num_phase_q;
							endcase
						end
						if (ch == CH_LF) begin
							// store at end of line, content length takes priority
							if (length_val_q == '0 && length_ok_q &&
							    column_q >= CW'(LENGTH_PREFIX_LEN))
								length_val_d = line_value;
							else if (status_val_q == '0 && status_ok_q &&
							         column_q >= CW'(STATUS_PREFIX_LEN))
								status_val_d = line_value;
							column_d    = '0;
							status_ok_d = 1'b1;
							length_ok_d = 1'b1;
							accum_d     = '0;
							num_phase_d = NUM_SKIP;
							negative_d  = 1'b0;
							nl_run_d    = nl_run_q + 2'd1;
							if (nl_run_q != 2'd0) phase_d = OUT_HEADER_END;
						end
					end
				end
				CMD_TICK: begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= timeout_q) phase_d = OUT_TIMEOUT;
				end
				CMD_CLOSE: begin
					phase_d = (byte_count_q == '0) ? OUT_CLOSED_EMPTY : OUT_CLOSED_BYTES;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= OUT_RUNNING;
			byte_count_q <= '0;
			column_q     <= '0;
			status_ok_q  <= 1'b1;
			length_ok_q  <= 1'b1;
			accum_q      <= '0;
			num_phase_q  <= NUM_SKIP;
			negative_q   <= 1'b0;
			nl_run_q     <= '0;
			elapsed_q    <= '0;
			status_val_q <= '0;
			length_val_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			column_q     <= column_d;
			status_ok_q  <= status_ok_d;
			length_ok_q  <= length_ok_d;
			accum_q      <= accum_d;
			num_phase_q  <= num_phase_d;
			negative_q   <= negative_d;
			nl_run_q     <= nl_run_d;
			elapsed_q    <= elapsed_d;
			status_val_q <= status_val_d;
			length_val_q <= length_val_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (accept) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp.outcome        <= phase_d;
			rsp.finished       <= (phase_d != OUT_RUNNING);
			rsp.status_code    <= status_val_d;
			rsp.content_length <= length_val_d;
		end
	end

	assign rsp.valid = out_valid_q;

	// a pending result that is not taken blocks the next item
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("item accepted while result stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted item produced no result");

	a_frozen_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != OUT_RUNNING && !(accept && cmd_t'(req.cmd) == CMD_START))
		|=> ($stable(byte_count_q) && $stable(status_val_q) && $stable(length_val_q)))
		else $error("scan state changed after finish");

	a_nl_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == OUT_RUNNING) |-> (nl_run_q < 2'd2))
		else $error("blank line seen but header end not flagged");

	a_column_cap: assert property (@(posedge clk) disable iff (!arst_n)
		column_q <= CW'(LINE_CAP - 1))
		else $error("column beyond line cap");

endmodule
